FILE: design/dpf_pkg.sv
// shared types and constants for the data packet framer
`timescale 1ns / 1ps

package dpf_pkg;

    localparam int unsigned CFG_IDX_W  = 8;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ADDRESS = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_SIZE     = 8'd1;

    localparam logic [31:0] ADDR_RESET  = 32'hFFFF_FFFF;
    localparam logic [1:0]  CHUNK_RESET = 2'd2;

    localparam logic [7:0] START_HI = 8'hEF;
    localparam logic [7:0] START_LO = 8'h01;
    localparam logic [7:0] PID_DATA = 8'h02;
    localparam logic [7:0] PID_END  = 8'h08;

    // byte positions within one framed item
    localparam logic [3:0] POS_START_HI = 4'd0;
    localparam logic [3:0] POS_START_LO = 4'd1;
    localparam logic [3:0] POS_ADDR_3   = 4'd2;
    localparam logic [3:0] POS_ADDR_2   = 4'd3;
    localparam logic [3:0] POS_ADDR_1   = 4'd4;
    localparam logic [3:0] POS_ADDR_0   = 4'd5;
    localparam logic [3:0] POS_PID      = 4'd6;
    localparam logic [3:0] POS_LEN_HI   = 4'd7;
    localparam logic [3:0] POS_LEN_LO   = 4'd8;
    localparam logic [3:0] POS_PAYLOAD  = 4'd9;
    localparam logic [3:0] POS_SUM_HI   = 4'd10;
    localparam logic [3:0] POS_SUM_LO   = 4'd11;

    // one classified payload byte, handed from front to back
    typedef struct packed {
        logic        hdr;
        logic [31:0] addr;
        logic [7:0]  pid;
        logic [8:0]  lenf;
        logic [7:0]  data;
        logic        tail;
        logic        fin;
        logic [15:0] sum;
    } cmd_t;

    function automatic logic [8:0] chunk_bytes(input logic [1:0] sel);
        chunk_bytes = 9'd32 << sel;
    endfunction

endpackage

FILE: design/dpf_front.sv
// front end: config registers, packet bookkeeping and classification of each byte
`timescale 1ns / 1ps

module dpf_front
    import dpf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [23:0]           s_tdata,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  q_full,
    output logic                  q_push,
    output cmd_t                  q_cmd
);

    logic [31:0] addr_reg, addr_next;
    logic [1:0]  sel_reg, sel_next;
    logic        in_xfer_reg, in_xfer_next;
    logic [15:0] left_reg, left_next;
    logic [8:0]  pkt_left_reg, pkt_left_next;
    logic [15:0] sum_reg, sum_next;
    logic        fin_reg, fin_next;

    logic [7:0]  pbyte;
    logic [15:0] xfer_len;
    logic        accept;
    logic        hdr;
    logic [15:0] left_eff;
    logic [8:0]  chunk;
    logic        more;
    logic [8:0]  count;
    logic [8:0]  lenf;
    logic [7:0]  pid;
    logic [15:0] sum_base;
    logic [15:0] sum_new;
    logic [8:0]  pkt_base;
    logic [8:0]  pkt_new;
    logic        tail;
    logic        fin;

    assign pbyte     = s_tdata[7:0];
    assign xfer_len  = s_tdata[23:8];
    assign s_tready  = !q_full;
    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;

    always_comb
    begin
        hdr      = !in_xfer_reg || (pkt_left_reg == 9'd0);
        left_eff = in_xfer_reg ? left_reg : ((xfer_len == 16'd0) ? 16'd1 : xfer_len);
        chunk    = chunk_bytes(sel_reg);
        more     = left_eff > {7'd0, chunk};
        count    = more ? chunk : left_eff[8:0];
        lenf     = count + 9'd2;
        pid      = more ? PID_DATA : PID_END;
        sum_base = hdr ? (16'(pid) + 16'(lenf[8]) + 16'(lenf[7:0])) : sum_reg;
        sum_new  = sum_base + {8'd0, pbyte};
        pkt_base = hdr ? count : pkt_left_reg;
        pkt_new  = pkt_base - 9'd1;
        tail     = (pkt_new == 9'd0);
        fin      = hdr ? !more : fin_reg;
    end

    always_comb
    begin
        q_push      = accept;
        q_cmd.hdr   = hdr;
        q_cmd.addr  = addr_reg;
        q_cmd.pid   = pid;
        q_cmd.lenf  = lenf;
        q_cmd.data  = pbyte;
        q_cmd.tail  = tail;
        q_cmd.fin   = fin;
        q_cmd.sum   = sum_new;
    end

    always_comb
    begin
        addr_next     = addr_reg;
        sel_next      = sel_reg;
        in_xfer_next  = in_xfer_reg;
        left_next     = left_reg;
        pkt_left_next = pkt_left_reg;
        sum_next      = sum_reg;
        fin_next      = fin_reg;
        if (cfg_valid)
        begin
            if (cfg_index == CFG_DEVICE_ADDRESS)
                addr_next = cfg_data[31:0];
            else if (cfg_index == CFG_CHUNK_SIZE)
                sel_next = cfg_data[1:0];
        end
        if (accept)
        begin
            pkt_left_next = pkt_new;
            if (tail && fin)
            begin
                in_xfer_next = 1'b0;
                left_next    = 16'd0;
                sum_next     = 16'd0;
                fin_next     = 1'b0;
            end
            else
            begin
                in_xfer_next = 1'b1;
                left_next    = left_eff - 16'd1;
                sum_next     = tail ? 16'd0 : sum_new;
                fin_next     = fin;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg     <= ADDR_RESET;
            sel_reg      <= CHUNK_RESET;
            in_xfer_reg  <= 1'b0;
            left_reg     <= 16'd0;
            pkt_left_reg <= 9'd0;
            sum_reg      <= 16'd0;
            fin_reg      <= 1'b0;
        end
        else
        begin
            addr_reg     <= addr_next;
            sel_reg      <= sel_next;
            in_xfer_reg  <= in_xfer_next;
            left_reg     <= left_next;
            pkt_left_reg <= pkt_left_next;
            sum_reg      <= sum_next;
            fin_reg      <= fin_next;
        end
    end

endmodule

FILE: design/dpf_queue.sv
// short command queue between front and back
`timescale 1ns / 1ps

module dpf_queue
    import dpf_pkg::*;
#(
    parameter int unsigned DEPTH = 4
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output cmd_t head,
    output logic empty
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    cmd_t          slot_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          do_push;
    logic          do_pop;

    assign full    = (cnt_reg == CW'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign head    = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

FILE: design/dpf_back.sv
// back end: serialises each command: header if first, payload, checksum if last
`timescale 1ns / 1ps

module dpf_back
    import dpf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cmd_t       head,
    input  logic       empty,
    output logic       pop,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic       m_tlast,
    output logic [1:0] m_tuser
);

    logic [3:0] idx_reg, idx_next;
    logic       started_reg, started_next;
    logic       ov_reg, ov_next;
    logic [7:0] byte_reg, byte_next;
    logic       last_reg, last_next;
    logic       pend_reg, pend_next;
    logic       tend_reg, tend_next;

    logic       advance;
    logic [3:0] pos;
    logic [3:0] end_pos;
    logic       at_end;
    logic [7:0] sel_byte;

    assign advance = !empty && (!ov_reg || m_tready);
    assign pos     = started_reg ? idx_reg : (head.hdr ? POS_START_HI : POS_PAYLOAD);
    assign end_pos = head.tail ? POS_SUM_LO : POS_PAYLOAD;
    assign at_end  = (pos == end_pos);
    assign pop     = advance && at_end;

    always_comb
    begin
        unique case (pos)
            POS_START_HI: sel_byte = START_HI;
            POS_START_LO: sel_byte = START_LO;
            POS_ADDR_3:   sel_byte = head.addr[31:24];
            POS_ADDR_2:   sel_byte = head.addr[23:16];
            POS_ADDR_1:   sel_byte = head.addr[15:8];
            POS_ADDR_0:   sel_byte = head.addr[7:0];
            POS_PID:      sel_byte = head.pid;
            POS_LEN_HI:   sel_byte = {7'd0, head.lenf[8]};
            POS_LEN_LO:   sel_byte = head.lenf[7:0];
            POS_PAYLOAD:  sel_byte = head.data;
            POS_SUM_HI:   sel_byte = head.sum[15:8];
            POS_SUM_LO:   sel_byte = head.sum[7:0];
            default:      sel_byte = 8'd0;
        endcase
    end

    always_comb
    begin
        idx_next     = idx_reg;
        started_next = started_reg;
        ov_next      = ov_reg;
        byte_next    = byte_reg;
        last_next    = last_reg;
        pend_next    = pend_reg;
        tend_next    = tend_reg;
        if (advance)
        begin
            ov_next   = 1'b1;
            byte_next = sel_byte;
            last_next = at_end;
            pend_next = (pos == POS_SUM_LO);
            tend_next = (pos == POS_SUM_LO) && head.fin;
            if (at_end)
                started_next = 1'b0;
            else
            begin
                started_next = 1'b1;
                idx_next     = pos + 4'd1;
            end
        end
        else if (m_tready)
            ov_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg     <= POS_START_HI;
            started_reg <= 1'b0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            idx_reg     <= idx_next;
            started_reg <= started_next;
            ov_reg      <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        last_reg <= last_next;
        pend_reg <= pend_next;
        tend_reg <= tend_next;
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = byte_reg;
    assign m_tlast  = last_reg;
    assign m_tuser  = {tend_reg, pend_reg};

endmodule

FILE: design/data_packet_framer.sv
// top level of the data packet framer
// path: an accepted payload byte passes the command queue and the output byte register
// throughput: one output byte per cycle unless m_tready stalls; a payload byte gives 1, 3,
//   10 or 12 bytes (header, payload, checksum), set by the single-byte output serialiser
// input is taken every cycle while the command queue has room
// reset: asynchronous, clears control state; address resets to all ones, chunk select to 128
`timescale 1ns / 1ps

module data_packet_framer
    import dpf_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 4
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [23:0]           s_tdata,   // [7:0] payload_byte, [23:8] transfer_length
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,   // [7:0] out_byte
    output logic                  m_tlast,
    output logic [1:0]            m_tuser,   // [0] packet_end, [1] transfer_end
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cmd_t q_cmd;
    cmd_t q_head;
    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_empty;

    dpf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (q_cmd)
    );

    dpf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .head     (q_head),
        .empty    (q_empty)
    );

    dpf_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (q_head),
        .empty    (q_empty),
        .pop      (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

FILE: design/dpf_checker.sv
// port-level checks on the framer output stream, bound to the top level
`timescale 1ns / 1ps

module dpf_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast,
    input logic [1:0] m_tuser
);

    // transfer end only ever marks a packet end
    a_tend_on_pend: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> m_tuser[0])
        else $error("transfer end without packet end");

    // a packet end is always the last byte caused by its input
    a_pend_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tlast)
        else $error("packet end not on last byte of run");

    // stalled beat holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
            && $stable(m_tuser))
        else $error("stalled output beat changed");

    // nothing is offered while reset is held
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !m_tvalid)
        else $error("output valid during reset");

endmodule

bind data_packet_framer dpf_checker u_dpf_checker (.*);
